>>> design/escape_time_fractal_iteration_defines.svh
// assertion macros for the escape-time fractal iteration block
// no dependencies; included by the modules that carry assertions
`ifndef ESCAPE_TIME_FRACTAL_ITERATION_DEFINES_SVH
`define ESCAPE_TIME_FRACTAL_ITERATION_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ETF_ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("etf assertion failed");

// next-cycle implication
`define ETF_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("etf assertion failed");

`else

`define ETF_ASSERT_IMPLIES(label, clk, rst, pre, post)
`define ETF_ASSERT_NEXT(label, clk, rst, pre, post)

`endif

`endif

>>> design/etf_pkg.sv
// types, constants and saturating helpers for the escape-time fractal block
// no dependencies
`timescale 1ns / 1ps

package etf_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int FRAC_BITS   = 28;
   localparam int CNT_WIDTH   = 16;
   localparam int MODE_WIDTH  = 2;
   localparam int CSR_IDX_WIDTH = 2;

   localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
   localparam logic signed [COORD_WIDTH-1:0] FOUR =
      (FRAC_BITS + 2 < COORD_WIDTH - 1) ? (COORD_WIDTH'(4) << FRAC_BITS) : COORD_MAX;

   localparam logic [MODE_WIDTH-1:0] MODE_MANDEL = 2'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_JULIA  = 2'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_SHIP   = 2'd2;

   localparam logic [CSR_IDX_WIDTH-1:0] REG_MODE     = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_MAX_ITER = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_JULIA_RE = 2'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_JULIA_IM = 2'd3;

   localparam logic [CNT_WIDTH-1:0] MAX_ITER_RESET = 16'd256;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] point_real;
      logic signed [COORD_WIDTH-1:0] point_imag;
   } req_payload_type;

   typedef struct packed {
      logic [CNT_WIDTH-1:0] iteration_count;
      logic                 inside_res;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_RR,
      ST_MUL_II,
      ST_MUL_RI,
      ST_UPDATE,
      ST_CHECK,
      ST_DONE
   } etf_state_type;

   function automatic logic signed [COORD_WIDTH-1:0] sat_add(
      input logic signed [COORD_WIDTH-1:0] a,
      input logic signed [COORD_WIDTH-1:0] b);
      logic signed [COORD_WIDTH:0] s;
      s = {a[COORD_WIDTH-1], a} + {b[COORD_WIDTH-1], b};
      if (s[COORD_WIDTH] != s[COORD_WIDTH-1]) begin
         return s[COORD_WIDTH] ? COORD_MIN : COORD_MAX;
      end
      return s[COORD_WIDTH-1:0];
   endfunction

   function automatic logic signed [COORD_WIDTH-1:0] sat_sub(
      input logic signed [COORD_WIDTH-1:0] a,
      input logic signed [COORD_WIDTH-1:0] b);
      logic signed [COORD_WIDTH:0] s;
      s = {a[COORD_WIDTH-1], a} - {b[COORD_WIDTH-1], b};
      if (s[COORD_WIDTH] != s[COORD_WIDTH-1]) begin
         return s[COORD_WIDTH] ? COORD_MIN : COORD_MAX;
      end
      return s[COORD_WIDTH-1:0];
   endfunction

   function automatic logic signed [COORD_WIDTH-1:0] sat_abs(
      input logic signed [COORD_WIDTH-1:0] a);
      if (!a[COORD_WIDTH-1]) begin
         return a;
      end
      if (a == COORD_MIN) begin
         return COORD_MAX;
      end
      return -a;
   endfunction

endpackage

>>> design/escape_time_fractal_iteration.sv
// Escape-time fractal iteration (Mandelbrot, Julia, Burning Ship) in Q3.28
// fixed point. One point is taken at a time; one shared 32x32 multiplier
// forms re*re, im*im and re*im on successive cycles; Burning Ship mode adds
// an escape compare state to each iteration. The default limit is 256, and
// the next point can be taken in the same cycle as the result appears. The
// result sits in an output register, so a new point is taken while the
// previous result waits to be transferred.
// Depends on etf_pkg and escape_time_fractal_iteration_defines.svh.
`timescale 1ns / 1ps
`include "escape_time_fractal_iteration_defines.svh"

module escape_time_fractal_iteration (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  etf_pkg::req_payload_type                req_payload,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output etf_pkg::rsp_payload_type                rsp_payload,
   input  logic                                    csr_write,
   input  logic [etf_pkg::CSR_IDX_WIDTH-1:0]       csr_index,
   input  logic [etf_pkg::COORD_WIDTH-1:0]         csr_wdata
);

   localparam int W     = etf_pkg::COORD_WIDTH;
   localparam int F     = etf_pkg::FRAC_BITS;
   localparam int MAG_W = 2 * W - F;
   localparam logic [MAG_W-1:0] MAG_LIM = {{(MAG_W-1){1'b0}}, 1'b1} << (W - 1);

   // configuration
   logic [etf_pkg::MODE_WIDTH-1:0] mode_ff;
   logic [etf_pkg::CNT_WIDTH-1:0]  max_iter_ff;
   logic signed [W-1:0]            julia_re_ff;
   logic signed [W-1:0]            julia_im_ff;

   // iteration state
   etf_pkg::etf_state_type state_ff, state_in;
   logic signed [W-1:0] zr_ff, zr_in;
   logic signed [W-1:0] zi_ff, zi_in;
   logic signed [W-1:0] cr_ff, cr_in;
   logic signed [W-1:0] ci_ff, ci_in;
   logic                ship_ff, ship_in;
   logic [etf_pkg::CNT_WIDTH-1:0] iter_ff, iter_in;
   logic signed [W-1:0] rr_ff, rr_in;
   logic signed [W-1:0] ii_ff, ii_in;
   logic signed [W-1:0] ri_ff, ri_in;
   logic [etf_pkg::CNT_WIDTH-1:0] res_count_ff, res_count_in;
   logic                res_inside_ff, res_inside_in;
   logic                rsp_valid_ff, rsp_valid_in;
   etf_pkg::rsp_payload_type rsp_payload_ff, rsp_payload_in;

   // shared multiplier
   logic signed [W-1:0] za, zb, op_a, op_b, mul_res;
   logic [W-1:0]        mag_a, mag_b;
   logic [2*W-1:0]      prod;
   logic [MAG_W-1:0]    mag;
   logic                neg;

   logic                req_xfer, slot_free, at_limit, escaped;
   logic signed [W-1:0] mag_sum, new_re, new_im;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= etf_pkg::MODE_MANDEL;
         max_iter_ff <= etf_pkg::MAX_ITER_RESET;
         julia_re_ff <= '0;
         julia_im_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            etf_pkg::REG_MODE:     mode_ff     <= csr_wdata[etf_pkg::MODE_WIDTH-1:0];
            etf_pkg::REG_MAX_ITER: max_iter_ff <= csr_wdata[etf_pkg::CNT_WIDTH-1:0];
            etf_pkg::REG_JULIA_RE: julia_re_ff <= csr_wdata;
            etf_pkg::REG_JULIA_IM: julia_im_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      za = ship_ff ? etf_pkg::sat_abs(zr_ff) : zr_ff;
      zb = ship_ff ? etf_pkg::sat_abs(zi_ff) : zi_ff;
      case (state_ff)
         etf_pkg::ST_MUL_RR: begin
            op_a = za;
            op_b = za;
         end
         etf_pkg::ST_MUL_II: begin
            op_a = zb;
            op_b = zb;
         end
         default: begin
            op_a = za;
            op_b = zb;
         end
      endcase
      neg   = op_a[W-1] ^ op_b[W-1];
      mag_a = op_a[W-1] ? W'(-op_a) : W'(op_a);
      mag_b = op_b[W-1] ? W'(-op_b) : W'(op_b);
      prod  = mag_a * mag_b;
      mag   = prod[2*W-1:F];
      if (!neg) begin
         mul_res = (mag >= MAG_LIM) ? etf_pkg::COORD_MAX : mag[W-1:0];
      end else begin
         mul_res = (mag > MAG_LIM) ? etf_pkg::COORD_MIN : -mag[W-1:0];
      end
   end

   assign mag_sum = etf_pkg::sat_add(rr_ff, ii_ff);
   assign new_re  = etf_pkg::sat_add(etf_pkg::sat_sub(rr_ff, ii_ff), cr_ff);
   assign new_im  = etf_pkg::sat_add(etf_pkg::sat_add(ri_ff, ri_ff), ci_ff);
   assign at_limit = (iter_ff == max_iter_ff);
   assign escaped  = (zr_ff > etf_pkg::FOUR) || (zi_ff > etf_pkg::FOUR);
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_xfer  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= etf_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      zr_ff          <= zr_in;
      zi_ff          <= zi_in;
      cr_ff          <= cr_in;
      ci_ff          <= ci_in;
      ship_ff        <= ship_in;
      iter_ff        <= iter_in;
      rr_ff          <= rr_in;
      ii_ff          <= ii_in;
      ri_ff          <= ri_in;
      res_count_ff   <= res_count_in;
      res_inside_ff  <= res_inside_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   always_comb begin
      state_in       = state_ff;
      zr_in          = zr_ff;
      zi_in          = zi_ff;
      cr_in          = cr_ff;
      ci_in          = ci_ff;
      ship_in        = ship_ff;
      iter_in        = iter_ff;
      rr_in          = rr_ff;
      ii_in          = ii_ff;
      ri_in          = ri_ff;
      res_count_in   = res_count_ff;
      res_inside_in  = res_inside_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      req_stall      = (state_ff != etf_pkg::ST_IDLE);

      unique case (state_ff)
         etf_pkg::ST_IDLE: begin
            if (req_valid) begin
               ship_in = (mode_ff == etf_pkg::MODE_SHIP);
               iter_in = '0;
               if (mode_ff == etf_pkg::MODE_JULIA) begin
                  zr_in = req_payload.point_real;
                  zi_in = req_payload.point_imag;
                  cr_in = julia_re_ff;
                  ci_in = julia_im_ff;
               end else begin
                  zr_in = '0;
                  zi_in = '0;
                  cr_in = req_payload.point_real;
                  ci_in = req_payload.point_imag;
               end
               state_in = etf_pkg::ST_MUL_RR;
            end
         end
         etf_pkg::ST_MUL_RR: begin
            rr_in    = mul_res;
            state_in = etf_pkg::ST_MUL_II;
         end
         etf_pkg::ST_MUL_II: begin
            ii_in    = mul_res;
            state_in = etf_pkg::ST_MUL_RI;
         end
         etf_pkg::ST_MUL_RI: begin
            ri_in    = mul_res;
            state_in = etf_pkg::ST_UPDATE;
         end
         etf_pkg::ST_UPDATE: begin
            if (at_limit) begin
               res_count_in  = iter_ff;
               res_inside_in = 1'b1;
               state_in      = etf_pkg::ST_DONE;
            end else if (!ship_ff && (mag_sum > etf_pkg::FOUR)) begin
               res_count_in  = iter_ff;
               res_inside_in = 1'b0;
               state_in      = etf_pkg::ST_DONE;
            end else begin
               zr_in = new_re;
               zi_in = new_im;
               if (ship_ff) begin
                  state_in = etf_pkg::ST_CHECK;
               end else begin
                  iter_in  = iter_ff + 1'b1;
                  state_in = etf_pkg::ST_MUL_RR;
               end
            end
         end
         etf_pkg::ST_CHECK: begin
            if (escaped) begin
               res_count_in  = iter_ff;
               res_inside_in = 1'b0;
               state_in      = etf_pkg::ST_DONE;
            end else begin
               iter_in  = iter_ff + 1'b1;
               state_in = etf_pkg::ST_MUL_RR;
            end
         end
         etf_pkg::ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in                   = 1'b1;
               rsp_payload_in.iteration_count = res_count_ff;
               rsp_payload_in.inside_res      = res_inside_ff;
               state_in                       = etf_pkg::ST_IDLE;
            end
         end
         default: state_in = etf_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   `ETF_ASSERT_NEXT(a_start_mul, clock, reset, req_xfer, state_ff == etf_pkg::ST_MUL_RR)
   `ETF_ASSERT_IMPLIES(a_iter_bound, clock, reset, state_ff != etf_pkg::ST_IDLE, iter_ff <= max_iter_ff)
   `ETF_ASSERT_IMPLIES(a_inside_count, clock, reset, rsp_valid_ff && rsp_payload_ff.inside_res, rsp_payload_ff.iteration_count == max_iter_ff)
   `ETF_ASSERT_NEXT(a_done_hold, clock, reset, (state_ff == etf_pkg::ST_DONE) && !slot_free, state_ff == etf_pkg::ST_DONE)

endmodule

>>> test/escape_time_fractal_iteration_checker.sv
// result checker for the escape-time fractal iteration block: tracks the csr writes,
// predicts the iteration count and inside flag of every point and compares the results
// depends on etf_pkg
`timescale 1ns / 1ps

module escape_time_fractal_iteration_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  etf_pkg::req_payload_type          req_payload,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  etf_pkg::rsp_payload_type          rsp_payload,
   input  logic                              csr_write,
   input  logic [etf_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [etf_pkg::COORD_WIDTH-1:0]   csr_wdata,
   output int                                failures,
   output int                                pending
);
   import etf_pkg::*;

   typedef logic signed [COORD_WIDTH-1:0] fixed_t;

   localparam longint UPPER = longint'(COORD_MAX);
   localparam longint LOWER = longint'(COORD_MIN);

   logic [MODE_WIDTH-1:0] cur_mode;
   logic [CNT_WIDTH-1:0]  cur_limit;
   fixed_t                cur_c_re;
   fixed_t                cur_c_im;
   rsp_payload_type       expected_results[$];

   function automatic fixed_t clamp_fixed(input longint v);
      if (v > UPPER) begin
         return COORD_MAX;
      end
      if (v < LOWER) begin
         return COORD_MIN;
      end
      return fixed_t'(v);
   endfunction

   function automatic fixed_t fixed_add(input fixed_t a, input fixed_t b);
      return clamp_fixed(longint'(a) + longint'(b));
   endfunction

   // product of magnitudes, truncated toward zero, then signed and clamped
   function automatic fixed_t fixed_mul(input fixed_t a, input fixed_t b);
      longint ma;
      longint mb;
      longint mag;
      ma = a[COORD_WIDTH-1] ? -longint'(a) : longint'(a);
      mb = b[COORD_WIDTH-1] ? -longint'(b) : longint'(b);
      mag = (ma * mb) >>> FRAC_BITS;
      return clamp_fixed((a[COORD_WIDTH-1] ^ b[COORD_WIDTH-1]) ? -mag : mag);
   endfunction

   function automatic void square_plus(inout fixed_t re, inout fixed_t im,
                                       input fixed_t cr, input fixed_t ci);
      fixed_t rr;
      fixed_t ii;
      fixed_t ri;
      rr = fixed_mul(re, re);
      ii = fixed_mul(im, im);
      ri = fixed_mul(re, im);
      re = fixed_add(clamp_fixed(longint'(rr) - longint'(ii)), cr);
      im = fixed_add(fixed_add(ri, ri), ci);
   endfunction

   function automatic rsp_payload_type predict_escape(input req_payload_type p);
      fixed_t zr;
      fixed_t zi;
      fixed_t cr;
      fixed_t ci;
      int unsigned n;
      rsp_payload_type r;
      n = 0;
      if (cur_mode == MODE_SHIP) begin
         zr = '0;
         zi = '0;
         for (n = 0; n < cur_limit; n++) begin
            zr = clamp_fixed(zr[COORD_WIDTH-1] ? -longint'(zr) : longint'(zr));
            zi = clamp_fixed(zi[COORD_WIDTH-1] ? -longint'(zi) : longint'(zi));
            square_plus(zr, zi, p.point_real, p.point_imag);
            if (zi > FOUR || zr > FOUR) begin
               r.iteration_count = n[CNT_WIDTH-1:0];
               r.inside_res = 1'b0;
               return r;
            end
         end
         r.iteration_count = cur_limit;
         r.inside_res = 1'b1;
         return r;
      end
      if (cur_mode == MODE_JULIA) begin
         zr = p.point_real;
         zi = p.point_imag;
         cr = cur_c_re;
         ci = cur_c_im;
      end else begin
         zr = '0;
         zi = '0;
         cr = p.point_real;
         ci = p.point_imag;
      end
      while (n < cur_limit && fixed_add(fixed_mul(zr, zr), fixed_mul(zi, zi)) <= FOUR) begin
         square_plus(zr, zi, cr, ci);
         n++;
      end
      r.iteration_count = n[CNT_WIDTH-1:0];
      r.inside_res = (n == cur_limit);
      return r;
   endfunction

   always @(posedge clock) begin : track
      rsp_payload_type want;
      if (reset) begin
         cur_mode = MODE_MANDEL;
         cur_limit = MAX_ITER_RESET;
         cur_c_re = '0;
         cur_c_im = '0;
         expected_results.delete();
         failures = 0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               REG_MODE:     cur_mode = csr_wdata[MODE_WIDTH-1:0];
               REG_MAX_ITER: cur_limit = csr_wdata[CNT_WIDTH-1:0];
               REG_JULIA_RE: cur_c_re = csr_wdata;
               REG_JULIA_IM: cur_c_im = csr_wdata;
            endcase
         end
         if (req_valid && !req_stall) begin
            expected_results.push_back(predict_escape(req_payload));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("result transfer with nothing expected: iteration_count %0d inside_res %0d",
                      rsp_payload.iteration_count, rsp_payload.inside_res);
               failures++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_payload.iteration_count !== want.iteration_count) begin
                  $error("iteration_count: expected %0d, actual %0d",
                         want.iteration_count, rsp_payload.iteration_count);
                  failures++;
               end
               if (rsp_payload.inside_res !== want.inside_res) begin
                  $error("inside_res: expected %0d, actual %0d",
                         want.inside_res, rsp_payload.inside_res);
                  failures++;
               end
            end
         end
      end
      pending = expected_results.size();
   end

endmodule

>>> test/tb_escape_time_fractal_iteration.sv
// top of the escape-time fractal iteration testbench: clock, reset, csr settings,
// point stimulus and result stalls, with the verdict taken from the checker
// depends on etf_pkg, escape_time_fractal_iteration and its checker
`timescale 1ns / 1ps

module tb_escape_time_fractal_iteration;
   import etf_pkg::*;

   typedef logic signed [COORD_WIDTH-1:0] fixed_t;

   localparam logic [MODE_WIDTH-1:0] MODE_SPARE = 2'd3;
   localparam int RANDOM_PHASES = 11;
   localparam int PHASE_POINTS = 150;
   localparam int HOLD_OFF_CYCLES = 2000;
   localparam int WATCHDOG_LIMIT = 20000;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   req_payload_type          req_payload;
   logic                     rsp_valid;
   logic                     rsp_stall;
   rsp_payload_type          rsp_payload;
   logic                     csr_write;
   logic [CSR_IDX_WIDTH-1:0] csr_index;
   logic [COORD_WIDTH-1:0]   csr_wdata;
   int                       failures;
   int                       pending;
   int                       quiet_cycles;
   bit                       sender_calm;

   escape_time_fractal_iteration dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   escape_time_fractal_iteration_checker result_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .failures    (failures),
      .pending     (pending)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic fixed_t to_fixed(input real x);
      return fixed_t'($rtoi(x * (2.0 ** FRAC_BITS)));
   endfunction

   // mostly the interesting region around the origin, some tiny and some full-range values
   function automatic fixed_t random_coord();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
         return $signed($urandom_range(0, 1342177280)) - 671088640;
      end
      if (pick == 7) begin
         return $signed($urandom()) >>> 8;
      end
      return $urandom();
   endfunction

   task automatic offer_point(input fixed_t re, input fixed_t im);
      int unsigned gap;
      gap = sender_calm ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= '{point_real: re, point_imag: im};
      do @(posedge clock); while (!(req_valid && !req_stall));
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_settings(input logic [MODE_WIDTH-1:0] mode,
                                 input logic [CNT_WIDTH-1:0] limit,
                                 input fixed_t c_re, input fixed_t c_im);
      wait_idle();
      csr_write <= 1'b1;
      csr_index <= REG_MODE;
      csr_wdata <= COORD_WIDTH'(mode);
      @(negedge clock);
      csr_index <= REG_MAX_ITER;
      csr_wdata <= COORD_WIDTH'(limit);
      @(negedge clock);
      csr_index <= REG_JULIA_RE;
      csr_wdata <= c_re;
      @(negedge clock);
      csr_index <= REG_JULIA_IM;
      csr_wdata <= c_im;
      @(negedge clock);
      csr_write <= 1'b0;
      @(negedge clock);
   endtask

   // no transfer on either channel for too long ends the run
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : result_sink
      int unsigned hold;
      int unsigned taken;
      bit calm;
      taken = 0;
      calm = 1'b0;
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         if (taken % 30 == 0) begin
            calm = ($urandom_range(0, 3) == 0);
         end
         // one long hold-off so the block fills and stalls its input
         if (taken == 40) begin
            hold = HOLD_OFF_CYCLES;
         end else begin
            hold = calm ? 0 : $urandom_range(0, 18);
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         taken++;
         @(negedge clock);
      end
   end

   initial begin : stimulus
      logic [CNT_WIDTH-1:0] limit;
      fixed_t c_re;
      fixed_t c_im;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_write = 1'b0;
      csr_index = REG_MODE;
      csr_wdata = '0;
      sender_calm = 1'b0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // reset settings: mandelbrot, limit 256, boundary points on the real axis, extreme corners and two other points
      offer_point('0, '0);
      offer_point(to_fixed(-2.0), '0);
      offer_point(to_fixed(2.0), '0);
      offer_point(COORD_MAX, COORD_MAX);
      offer_point(COORD_MIN, COORD_MIN);
      offer_point(COORD_MIN, COORD_MAX);
      offer_point(to_fixed(-0.75), to_fixed(0.1));
      offer_point(to_fixed(0.25), to_fixed(0.5));

      write_settings(MODE_JULIA, 16'd64, to_fixed(-0.8), to_fixed(0.156));
      offer_point('0, '0);
      offer_point(COORD_MAX, COORD_MIN);
      offer_point(to_fixed(0.3), to_fixed(-0.5));
      offer_point(to_fixed(-0.1), to_fixed(0.7));

      write_settings(MODE_SHIP, 16'd64, '0, '0);
      offer_point('0, '0);
      offer_point(to_fixed(-1.75), to_fixed(-0.03));
      offer_point(to_fixed(-2.0), '0);
      offer_point(COORD_MAX, COORD_MAX);
      offer_point(COORD_MIN, COORD_MIN);

      // unused mode code falls back to mandelbrot
      write_settings(MODE_SPARE, 16'd16, '0, '0);
      offer_point('0, '0);
      offer_point(to_fixed(1.0), '0);

      // zero limit
      write_settings(MODE_MANDEL, 16'd0, '0, '0);
      offer_point('0, '0);
      offer_point(COORD_MAX, COORD_MAX);
      write_settings(MODE_SHIP, 16'd0, '0, '0);
      offer_point('0, '0);

      // largest limit and extreme julia constants, only with points that escape early
      write_settings(MODE_MANDEL, 16'hFFFF, COORD_MAX, COORD_MIN);
      offer_point(to_fixed(1.0), '0);
      offer_point(COORD_MIN, COORD_MIN);
      write_settings(MODE_JULIA, 16'hFFFF, COORD_MAX, COORD_MIN);
      offer_point('0, '0);
      write_settings(MODE_SHIP, 16'hFFFF, COORD_MIN, COORD_MAX);
      offer_point(COORD_MAX, COORD_MAX);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case ($urandom_range(0, 7))
            0:       limit = 16'd1;
            1:       limit = 16'd2;
            2, 3, 4: limit = CNT_WIDTH'($urandom_range(3, 40));
            5:       limit = 16'd64;
            6:       limit = CNT_WIDTH'($urandom_range(100, 256));
            default: limit = 16'd256;
         endcase
         if ($urandom_range(0, 7) == 0) begin
            c_re = $urandom();
            c_im = $urandom();
         end else begin
            c_re = $signed($urandom_range(0, 1 << 29)) - (1 << 28);
            c_im = $signed($urandom_range(0, 1 << 29)) - (1 << 28);
         end
         write_settings(MODE_WIDTH'(phase % 4), limit, c_re, c_im);
         sender_calm = ($urandom_range(0, 3) == 0);
         repeat (PHASE_POINTS) offer_point(random_coord(), random_coord());
      end

      wait_idle();
      repeat (40) @(negedge clock);
      if (failures == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
